FILE: design/ocr_pkg.sv
// ----------------------------------------------------------------------------
// Ordered checkpoint ring package
// Shared widths, command and status codes, FSM states and beat structs.
// ----------------------------------------------------------------------------
package ocr_pkg;

  localparam int unsigned PosW             = 64;
  localparam int unsigned CmdW             = 2;
  localparam int unsigned StatusW          = 2;
  localparam int unsigned CountW           = 4;
  localparam int unsigned RingDepthDefault = 8;

  typedef enum logic [CmdW-1:0] {
    CMD_SHRINK = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_FRONT  = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_EVICTED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_FIN
  } state_e;

  // One stored checkpoint entry
  typedef struct packed {
    logic [PosW-1:0] record_ptr;
    logic [PosW-1:0] end_ptr;
    logic [PosW-1:0] redo;
  } entry_t;

  // One result beat
  typedef struct packed {
    status_e           status;
    logic              has_entry;
    logic [PosW-1:0]   front_record;
    logic [PosW-1:0]   front_end;
    logic [PosW-1:0]   front_redo;
    logic [CountW-1:0] count;
  } res_t;

endpackage

FILE: design/ocr_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ocr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write the addressed word
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/ocr_out.sv
// ----------------------------------------------------------------------------
// Ordered checkpoint ring output register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module ocr_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  ocr_pkg::res_t res_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output ocr_pkg::res_t res_o,
  output logic          free_o
);

  logic          valid_q, valid_d;
  ocr_pkg::res_t res_q;

  // Slot is free when empty or being drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the beat payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: design/ocr_seq.sv
// ----------------------------------------------------------------------------
// Ordered checkpoint ring sequencer
// Runs one command at a time against the entry RAM: read, compare, commit.
// ----------------------------------------------------------------------------
module ocr_seq #(
  parameter int unsigned RING_DEPTH = ocr_pkg::RingDepthDefault,
  localparam int unsigned IdxW      = $clog2(RING_DEPTH),
  localparam int unsigned CntW      = $clog2(RING_DEPTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command beat
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ocr_pkg::CmdW-1:0]  cmd_i,
  input  logic [ocr_pkg::PosW-1:0]  position_i,
  input  logic [ocr_pkg::PosW-1:0]  record_pointer_i,
  input  logic [ocr_pkg::PosW-1:0]  end_pointer_i,
  // entry RAM
  output logic                      rd_en_o,
  output logic [IdxW-1:0]           rd_addr_o,
  input  ocr_pkg::entry_t           rd_data_i,
  output logic                      wr_en_o,
  output logic [IdxW-1:0]           wr_addr_o,
  output ocr_pkg::entry_t           wr_data_o,
  // result beat
  input  logic                      out_free_i,
  output logic                      load_o,
  output ocr_pkg::res_t             res_o
);

  localparam logic [IdxW:0]   DepthIdx = (IdxW + 1)'(RING_DEPTH);
  localparam logic [CntW-1:0] DepthCnt = CntW'(RING_DEPTH);

  ocr_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]          head_q;
  logic [CntW-1:0]          fill_q;
  logic [CntW-1:0]          scan_q;
  logic                     reject_q;
  logic [ocr_pkg::CmdW-1:0] cmd_q;
  logic [ocr_pkg::PosW-1:0] pos_q;
  logic [ocr_pkg::PosW-1:0] rec_q;
  logic [ocr_pkg::PosW-1:0] end_q;
  ocr_pkg::entry_t          cap_q;

  logic            accept;
  logic            full;
  logic            redo_le;
  logic            scan_more;
  logic            commit;
  logic [IdxW-1:0] tail_slot;
  logic [IdxW-1:0] scan_slot;
  logic [IdxW-1:0] app_slot;
  logic [IdxW-1:0] drop_slot;
  logic [IdxW-1:0] new_head;
  logic [CntW-1:0] new_fill;
  ocr_pkg::status_e new_status;

  // Ring slot at an offset from a base, wrapping at the depth
  function automatic logic [IdxW-1:0] slot_f(input logic [IdxW-1:0] base,
                                             input logic [IdxW-1:0] off);
    logic [IdxW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DepthIdx) begin
      sum = sum - DepthIdx;
    end
    return sum[IdxW-1:0];
  endfunction

  assign accept    = in_valid_i && in_ready_o;
  assign full      = (fill_q == DepthCnt);
  assign tail_slot = slot_f(head_q, IdxW'(fill_q - CntW'(1)));
  assign scan_slot = slot_f(head_q, IdxW'(scan_q));
  assign drop_slot = slot_f(head_q, IdxW'(scan_q - CntW'(1)));
  assign app_slot  = full ? slot_f(head_q, IdxW'(RING_DEPTH - 1))
                          : slot_f(head_q, IdxW'(fill_q));
  assign redo_le   = (rd_data_i.redo <= pos_q);
  assign scan_more = ((scan_q + CntW'(1)) < fill_q);
  assign commit    = (state_q == ocr_pkg::S_FIN) && out_free_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ocr_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            ocr_pkg::CMD_SHRINK: begin
              state_d = (fill_q > CntW'(1)) ? ocr_pkg::S_READ : ocr_pkg::S_FIN;
            end
            ocr_pkg::CMD_INSERT,
            ocr_pkg::CMD_FRONT: begin
              state_d = (fill_q != '0) ? ocr_pkg::S_READ : ocr_pkg::S_FIN;
            end
            default: begin
              state_d = ocr_pkg::S_FIN;
            end
          endcase
        end
      end
      ocr_pkg::S_READ: begin
        state_d = ocr_pkg::S_CHECK;
      end
      ocr_pkg::S_CHECK: begin
        if (cmd_q == ocr_pkg::CMD_SHRINK && redo_le && scan_more) begin
          state_d = ocr_pkg::S_READ;
        end else begin
          state_d = ocr_pkg::S_FIN;
        end
      end
      ocr_pkg::S_FIN: begin
        if (out_free_i) begin
          state_d = ocr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ocr_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs: RAM access, commit values and the result beat
  always_comb begin
    in_ready_o = (state_q == ocr_pkg::S_IDLE);
    rd_en_o    = (state_q == ocr_pkg::S_READ);
    wr_en_o    = 1'b0;
    wr_addr_o  = app_slot;
    wr_data_o  = '{record_ptr: rec_q, end_ptr: end_q, redo: pos_q};
    new_head   = head_q;
    new_fill   = fill_q;
    new_status = ocr_pkg::ST_DONE;
    res_o      = '0;

    case (cmd_q)
      ocr_pkg::CMD_SHRINK: rd_addr_o = scan_slot;
      ocr_pkg::CMD_INSERT: rd_addr_o = tail_slot;
      default:             rd_addr_o = head_q;
    endcase

    case (cmd_q)
      ocr_pkg::CMD_SHRINK: begin
        if (scan_q > CntW'(1)) begin
          new_head = drop_slot;
          new_fill = fill_q - (scan_q - CntW'(1));
        end
      end
      ocr_pkg::CMD_INSERT: begin
        if (reject_q) begin
          new_status = ocr_pkg::ST_IGNORED;
        end else begin
          wr_en_o = commit;
          if (full) begin
            new_status = ocr_pkg::ST_EVICTED;
          end else begin
            new_fill = fill_q + CntW'(1);
          end
        end
      end
      ocr_pkg::CMD_FRONT: begin
        if (fill_q != '0) begin
          res_o.has_entry    = 1'b1;
          res_o.front_record = cap_q.record_ptr;
          res_o.front_end    = cap_q.end_ptr;
          res_o.front_redo   = cap_q.redo;
        end
      end
      default: begin
        new_status = ocr_pkg::ST_DONE;
      end
    endcase

    res_o.status = new_status;
    res_o.count  = ocr_pkg::CountW'(new_fill);
    load_o       = commit;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ocr_pkg::S_IDLE;
      head_q   <= '0;
      fill_q   <= '0;
      scan_q   <= '0;
      reject_q <= 1'b0;
      cmd_q    <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cmd_q    <= cmd_i;
        scan_q   <= CntW'(1);
        reject_q <= 1'b0;
      end
      if (state_q == ocr_pkg::S_CHECK) begin
        if (cmd_q == ocr_pkg::CMD_INSERT) begin
          reject_q <= (rd_data_i.redo > pos_q);
        end
        // advance the scan past a replayed entry
        if (cmd_q == ocr_pkg::CMD_SHRINK && redo_le) begin
          scan_q <= scan_q + CntW'(1);
        end
      end
      if (commit) begin
        head_q <= new_head;
        fill_q <= new_fill;
      end
    end
  end

  // Hold the command payload and the head entry read for front
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q <= position_i;
      rec_q <= record_pointer_i;
      end_q <= end_pointer_i;
    end
    if (state_q == ocr_pkg::S_CHECK && cmd_q == ocr_pkg::CMD_FRONT) begin
      cap_q <= rd_data_i;
    end
  end

  // Fill count never passes the ring depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DepthCnt)
    else $error("fill count above ring depth");

  // RAM writes only at commit of an insert
  a_write_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (commit && cmd_q == ocr_pkg::CMD_INSERT && !reject_q))
    else $error("RAM write outside insert commit");

  // An accepted beat always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ocr_pkg::S_IDLE))
    else $error("sequencer stayed idle after accept");

  // Head moves only when a shrink commits
  a_head_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q != $past(head_q)) |->
      ($past(commit) && $past(cmd_q) == ocr_pkg::CMD_SHRINK))
    else $error("head moved outside shrink commit");

endmodule

FILE: design/ordered_checkpoint_ring.sv
// ----------------------------------------------------------------------------
// Ordered checkpoint ring
// Ring of checkpoint entries in rising redo order with insert, shrink, front.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (in_valid_i/in_ready_o) carries cmd, position, record and
//   end pointer; result channel (out_valid_o/out_ready_i) returns one beat per
//   command with status, front fields and the entry count after it.
//   Entries live in one RAM of RING_DEPTH words (record, end, redo), read
//   with registered read data; head index and fill count are flops.
//   Commands run one at a time. Front and insert on a non-empty ring raise
//   result valid after the read, compare and commit steps; commands that need
//   no read go straight to commit. Shrink compares entries one by one, at most
//   RING_DEPTH-1: one RAM read and one compare per entry. The next command is
//   taken the cycle after commit, so the input stays not ready while a command
//   runs. Reset clears head and count; the ring starts empty and needs no
//   clearing pass. A stalled receiver holds the result in the output register;
//   one further command may then run up to commit and waits there for the slot.
// ----------------------------------------------------------------------------
module ordered_checkpoint_ring #(
  parameter int unsigned RING_DEPTH = ocr_pkg::RingDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ocr_pkg::CmdW-1:0]    cmd_i,
  input  logic [ocr_pkg::PosW-1:0]    position_i,
  input  logic [ocr_pkg::PosW-1:0]    record_pointer_i,
  input  logic [ocr_pkg::PosW-1:0]    end_pointer_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ocr_pkg::StatusW-1:0] status_o,
  output logic                        has_entry_o,
  output logic [ocr_pkg::PosW-1:0]    front_record_o,
  output logic [ocr_pkg::PosW-1:0]    front_end_o,
  output logic [ocr_pkg::PosW-1:0]    front_redo_o,
  output logic [ocr_pkg::CountW-1:0]  count_o
);

  localparam int unsigned IdxW = $clog2(RING_DEPTH);

  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  ocr_pkg::entry_t rd_data;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  ocr_pkg::entry_t wr_data;
  logic            out_free;
  logic            load;
  ocr_pkg::res_t   res_next;
  ocr_pkg::res_t   res_out;

  // Entry storage
  ocr_ram #(
    .WIDTH ($bits(ocr_pkg::entry_t)),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Command sequencer
  ocr_seq #(
    .RING_DEPTH (RING_DEPTH)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .position_i       (position_i),
    .record_pointer_i (record_pointer_i),
    .end_pointer_i    (end_pointer_i),
    .rd_en_o          (rd_en),
    .rd_addr_o        (rd_addr),
    .rd_data_i        (rd_data),
    .wr_en_o          (wr_en),
    .wr_addr_o        (wr_addr),
    .wr_data_o        (wr_data),
    .out_free_i       (out_free),
    .load_o           (load),
    .res_o            (res_next)
  );

  // Result register
  ocr_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (res_next),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out),
    .free_o      (out_free)
  );

  assign status_o       = res_out.status;
  assign has_entry_o    = res_out.has_entry;
  assign front_record_o = res_out.front_record;
  assign front_end_o    = res_out.front_end;
  assign front_redo_o   = res_out.front_redo;
  assign count_o        = res_out.count;

endmodule
